### design/erc_pkg.sv
`timescale 1ns / 1ps
package erc_pkg;

  localparam int OperandWidthDefault = 64;
  localparam int FieldWidth = 64;

  localparam logic signed [1:0] ORDER_LESS    = 2'sb11;
  localparam logic signed [1:0] ORDER_EQUAL   = 2'sb00;
  localparam logic signed [1:0] ORDER_GREATER = 2'sb01;

  typedef struct packed {
    logic [FieldWidth-1:0] left_num;
    logic [FieldWidth-1:0] left_den;
    logic [FieldWidth-1:0] right_num;
    logic [FieldWidth-1:0] right_den;
  } operands_t;

  typedef struct packed {
    logic signed [1:0] order;
    logic              bad_denominator;
  } result_t;

  // control from the sequencer to each serial divider
  typedef struct packed {
    logic load;   // take fresh operands
    logic swap;   // numerator <= denominator, denominator <= remainder
    logic shift;  // one restoring division step
  } div_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_EVAL,
    ST_DONE
  } state_t;

endpackage

### design/exact_rational_compare_unit.sv
`timescale 1ns / 1ps
// Exact comparison of two non-negative fractions a/b against c/d by continued
// fraction expansion. Raise start with the operands while busy is low; the
// transaction is taken at that edge and busy stays high until the result has
// been shown. The result appears on result with a done pulse, high for exactly
// one cycle, that cannot be held off, so sample it on that cycle. Each
// expansion step runs two bit-serial restoring dividers side by side, one
// quotient bit per cycle, over the full OPERAND_WIDTH-bit quotients, and
// then tests the remainders and swaps. Quotient bits are compared as they
// emerge, so a step that decides the order ends early. A zero denominator
// skips the expansion and sets bad_denominator. The expansion takes at most
// about 93 steps for 64-bit operands. Only the low OPERAND_WIDTH bits of each
// field are used.
module exact_rational_compare_unit #(
  parameter int OPERAND_WIDTH = erc_pkg::OperandWidthDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  erc_pkg::operands_t operands,
  output logic               busy,
  output logic               done,
  output erc_pkg::result_t   result
);
  import erc_pkg::*;

  localparam int CntWidth = $clog2(OPERAND_WIDTH);
  localparam logic [CntWidth-1:0] CntLast = CntWidth'(OPERAND_WIDTH - 1);

  state_t              state;
  state_t              state_next;
  logic [CntWidth-1:0] cnt;
  logic                flipped;
  result_t             res;

  // operands truncated to the datapath width
  logic [OPERAND_WIDTH-1:0] ln_in;
  logic [OPERAND_WIDTH-1:0] ld_in;
  logic [OPERAND_WIDTH-1:0] rn_in;
  logic [OPERAND_WIDTH-1:0] rd_in;
  logic                     bad_in;

  div_ctrl_t ctrl;
  logic      lq_bit;
  logic      rq_bit;
  logic      lr_zero;
  logic      rr_zero;

  // sequencer outputs
  logic    accept;
  logic    cnt_clear;
  logic    flip_clear;
  logic    flip_toggle;
  logic    res_load;
  result_t res_value;

  // helpers: sense of the order, corrected for the flip at odd depth
  logic              last_bit;
  logic              q_differ;
  logic signed [1:0] q_sense;
  logic signed [1:0] r_sense;

  assign ln_in  = operands.left_num[OPERAND_WIDTH-1:0];
  assign ld_in  = operands.left_den[OPERAND_WIDTH-1:0];
  assign rn_in  = operands.right_num[OPERAND_WIDTH-1:0];
  assign rd_in  = operands.right_den[OPERAND_WIDTH-1:0];
  assign bad_in = (ld_in == '0) || (rd_in == '0);

  assign accept   = start && (state == ST_IDLE);
  assign last_bit = (cnt == CntLast);
  assign q_differ = (lq_bit != rq_bit);

  // quotient bits come msb first, so the first differing bit decides
  always_comb begin
    if (rq_bit ^ flipped) begin
      q_sense = ORDER_LESS;
    end else begin
      q_sense = ORDER_GREATER;
    end
  end

  // a zero remainder means that fraction ends here, i.e. it is the smaller at even depth and the larger at odd depth
  always_comb begin
    if (lr_zero ^ flipped) begin
      r_sense = ORDER_LESS;
    end else begin
      r_sense = ORDER_GREATER;
    end
  end

  erc_serial_divider #(
    .WIDTH(OPERAND_WIDTH)
  ) u_left_div (
    .clk     (clk),
    .ctrl    (ctrl),
    .numer   (ln_in),
    .denom   (ld_in),
    .qbit    (lq_bit),
    .rem_zero(lr_zero)
  );

  erc_serial_divider #(
    .WIDTH(OPERAND_WIDTH)
  ) u_right_div (
    .clk     (clk),
    .ctrl    (ctrl),
    .numer   (rn_in),
    .denom   (rd_in),
    .qbit    (rq_bit),
    .rem_zero(rr_zero)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = bad_in ? ST_DONE : ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (q_differ) begin
          state_next = ST_DONE;
        end else if (last_bit) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (lr_zero || rr_zero) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SHIFT;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ctrl        = '0;
    cnt_clear   = 1'b0;
    flip_clear  = 1'b0;
    flip_toggle = 1'b0;
    res_load    = 1'b0;
    res_value   = '{order: ORDER_EQUAL, bad_denominator: 1'b0};
    case (state)
      ST_IDLE: begin
        if (accept) begin
          ctrl.load  = 1'b1;
          cnt_clear  = 1'b1;
          flip_clear = 1'b1;
          if (bad_in) begin
            res_load  = 1'b1;
            res_value = '{order: ORDER_EQUAL, bad_denominator: 1'b1};
          end
        end
      end
      ST_SHIFT: begin
        ctrl.shift = 1'b1;
        if (q_differ) begin
          res_load  = 1'b1;
          res_value = '{order: q_sense, bad_denominator: 1'b0};
        end
      end
      ST_EVAL: begin
        if (lr_zero && rr_zero) begin
          res_load  = 1'b1;
          res_value = '{order: ORDER_EQUAL, bad_denominator: 1'b0};
        end else if (lr_zero || rr_zero) begin
          res_load  = 1'b1;
          res_value = '{order: r_sense, bad_denominator: 1'b0};
        end else begin
          // next term: each fraction becomes denominator over remainder
          ctrl.swap   = 1'b1;
          cnt_clear   = 1'b1;
          flip_toggle = 1'b1;
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      flipped <= 1'b0;
    end else begin
      state <= state_next;
      if (cnt_clear) begin
        cnt <= '0;
      end else if (ctrl.shift) begin
        cnt <= cnt + 1'b1;
      end
      if (flip_clear) begin
        flipped <= 1'b0;
      end else if (flip_toggle) begin
        flipped <= ~flipped;
      end
    end
  end

  // result payload, held until the next transaction
  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_value;
    end
  end

  assign busy   = (state != ST_IDLE);
  assign done   = (state == ST_DONE);
  assign result = res;

endmodule

### design/erc_serial_divider.sv
`timescale 1ns / 1ps
module erc_serial_divider #(
  parameter int WIDTH = erc_pkg::OperandWidthDefault
) (
  input  logic                clk,
  input  erc_pkg::div_ctrl_t  ctrl,
  input  logic [WIDTH-1:0]    numer,
  input  logic [WIDTH-1:0]    denom,
  output logic                qbit,
  output logic                rem_zero
);
  import erc_pkg::*;

  logic [WIDTH-1:0] num;
  logic [WIDTH-1:0] den;
  logic [WIDTH-1:0] rem;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;

  // restoring step: bring down the next numerator bit, subtract if it fits
  assign trial    = {rem, num[WIDTH-1]};
  assign diff     = trial - {1'b0, den};
  assign qbit     = ~diff[WIDTH];
  assign rem_zero = (rem == '0);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      num <= numer;
      den <= denom;
      rem <= '0;
    end else if (ctrl.swap) begin
      num <= den;
      den <= rem;
      rem <= '0;
    end else if (ctrl.shift) begin
      num <= {num[WIDTH-2:0], 1'b0};
      rem <= qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
    end
  end

endmodule
